FILE: hw/rtl/cpsm_pkg.sv
`timescale 1ns / 1ps
// Package for the capture period speed meter.
// Field widths, register indexes, reset values, status codes and the config struct.
package cpsm_pkg;

    localparam int CAPTURE_W  = 16;
    localparam int SPEED_W    = 32;
    localparam int STATUS_W   = 3;
    localparam int MINP_W     = 16;
    localparam int TPM_W      = 32;
    localparam int PPR_W      = 8;
    localparam int STEP_W     = 32;
    localparam int TMO_W      = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_PERIOD       = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TICKS_PER_MINUTE = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PULSES_PER_REV   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_STEP         = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT_TICKS    = 3'd4;

    // reset values
    localparam logic [MINP_W-1:0] RST_MIN_PERIOD       = 16'd100;
    localparam logic [TPM_W-1:0]  RST_TICKS_PER_MINUTE = 32'd60000000;
    localparam logic [PPR_W-1:0]  RST_PULSES_PER_REV   = 8'd6;
    localparam logic [STEP_W-1:0] RST_MAX_STEP         = 32'd1000;
    localparam logic [TMO_W-1:0]  RST_TIMEOUT_TICKS    = 8'd10;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_GLITCH  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UPDATED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_KEPT    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TICK    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT = 3'd4;

    // item kind
    localparam logic CMD_EDGE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic [MINP_W-1:0] min_period;
        logic [TPM_W-1:0]  ticks_per_minute;
        logic [PPR_W-1:0]  pulses_per_rev;
        logic [STEP_W-1:0] max_step;
        logic [TMO_W-1:0]  timeout_ticks;
    } cfg_t;

endpackage

FILE: hw/rtl/cpsm_cfg.sv
`timescale 1ns / 1ps
// Configuration register file of the speed meter.
// Depends on cpsm_pkg for the register indexes, reset values and cfg_t.
module cpsm_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [cpsm_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [cpsm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output cpsm_pkg::cfg_t                  cfg
);
    import cpsm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_MIN_PERIOD:       cfg_next.min_period       = cfg_wdata[MINP_W-1:0];
                REG_TICKS_PER_MINUTE: cfg_next.ticks_per_minute = cfg_wdata[TPM_W-1:0];
                REG_PULSES_PER_REV:   cfg_next.pulses_per_rev   = cfg_wdata[PPR_W-1:0];
                REG_MAX_STEP:         cfg_next.max_step         = cfg_wdata[STEP_W-1:0];
                REG_TIMEOUT_TICKS:    cfg_next.timeout_ticks    = cfg_wdata[TMO_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_period       <= RST_MIN_PERIOD;
            cfg_reg.ticks_per_minute <= RST_TICKS_PER_MINUTE;
            cfg_reg.pulses_per_rev   <= RST_PULSES_PER_REV;
            cfg_reg.max_step         <= RST_MAX_STEP;
            cfg_reg.timeout_ticks    <= RST_TIMEOUT_TICKS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hw/rtl/cpsm_div.sv
`timescale 1ns / 1ps
// Restoring serial divider: one quotient bit per cycle.
// Standalone; a zero divisor yields an all-ones quotient.
module cpsm_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 25
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   trial_sub;
    logic             fits;

    // shift the next dividend bit into the partial remainder
    assign trial     = {rem_reg, quo_reg[NUM_W-1]};
    assign trial_sub = trial - {1'b0, den_reg};
    assign fits      = (trial >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

`ifndef SYNTH
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("divider not busy after start");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");
    a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !start && cnt_reg == CNT_W'(1)) |=> done_reg)
        else $error("divider missed done after last step");
`endif

endmodule

FILE: hw/rtl/capture_period_speed_meter.sv
`timescale 1ns / 1ps
// Top level of the capture period speed meter.
// Depends on cpsm_pkg, cpsm_cfg and cpsm_div.

// Each beat in gives one beat out. A tick, or an edge rejected as a glitch,
// is evaluated in S_EVAL and then written to the result register; an
// accepted edge goes on through S_MUL, S_DSTART, S_DWAIT and S_STEP, mostly
// in the 32 divider steps that give rev/min. The input is ready only while
// the sequencer is idle; a finished result waits in the output register, so
// the next beat can be taken before that result is consumed. Configuration
// writes take effect on the next cycle and should be made while idle.
module capture_period_speed_meter #(
    parameter int TIMER_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input beat
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [15:0]                     s_axis_tdata,  // [15:0] capture_value
    input  logic [0:0]                      s_axis_tuser,  // [0] cmd
    // result beat
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [31:0]                     m_axis_tdata,  // [31:0] speed
    output logic [2:0]                      m_axis_tuser,  // [2:0] status
    // configuration
    input  logic                            cfg_we,
    input  logic [cpsm_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [cpsm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import cpsm_pkg::*;

    localparam int PW = TIMER_BITS + 1;           // period width
    localparam int CW = (PW > MINP_W) ? PW : MINP_W;
    localparam int DW = PW + PPR_W;               // divisor width
    localparam logic [PW-1:0] TIMER_MAX = {1'b0, {TIMER_BITS{1'b1}}};

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EVAL   = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_DSTART = 3'd3;
    localparam logic [2:0] S_DWAIT  = 3'd4;
    localparam logic [2:0] S_STEP   = 3'd5;
    localparam logic [2:0] S_WB     = 3'd6;

    cfg_t cfg;

    logic [2:0]            state_reg, state_next;
    logic [TIMER_BITS-1:0] last_capture_reg, last_capture_next;
    logic [SPEED_W-1:0]    held_speed_reg, held_speed_next;
    logic [TMO_W-1:0]      idle_count_reg, idle_count_next;
    logic                  out_valid_reg, out_valid_next;

    logic                  cmd_reg, cmd_next;
    logic [TIMER_BITS-1:0] cap_reg, cap_next;
    logic [PW-1:0]         period_reg, period_next;
    logic [DW-1:0]         den_reg, den_next;
    logic [SPEED_W-1:0]    rel_reg, rel_next;
    logic [SPEED_W-1:0]    res_speed_reg, res_speed_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [TMO_W-1:0]      res_idle_reg, res_idle_next;
    logic [TIMER_BITS-1:0] res_last_reg, res_last_next;
    logic [SPEED_W-1:0]    out_speed_reg, out_speed_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;

    logic [PW-1:0]         period;
    logic                  glitch;
    logic [TMO_W-1:0]      idle_inc;
    logic [SPEED_W-1:0]    speed_diff;
    logic                  div_start;
    logic                  div_done;
    logic [SPEED_W-1:0]    div_quo;
    logic                  in_fire;
    logic                  out_load;

    cpsm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    cpsm_div #(
        .NUM_W (SPEED_W),
        .DEN_W (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cfg.ticks_per_minute),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign div_start = (state_reg == S_DSTART);
    assign out_load  = (state_reg == S_WB) && (!out_valid_reg || m_axis_tready);

    // wrap adds TIMER_MAX, so a wrapped period comes out one tick short
    assign period = (cap_reg > last_capture_reg)
                  ? ({1'b0, cap_reg} - {1'b0, last_capture_reg})
                  : ({1'b0, cap_reg} + TIMER_MAX - {1'b0, last_capture_reg});
    assign glitch   = CW'(period) < CW'(cfg.min_period);
    assign idle_inc = idle_count_reg + 1'b1;
    assign speed_diff = (rel_reg > held_speed_reg) ? (rel_reg - held_speed_reg)
                                                   : (held_speed_reg - rel_reg);

    always_comb
    begin
        state_next        = state_reg;
        last_capture_next = last_capture_reg;
        held_speed_next   = held_speed_reg;
        idle_count_next   = idle_count_reg;
        out_valid_next    = out_valid_reg;
        cmd_next          = cmd_reg;
        cap_next          = cap_reg;
        period_next       = period_reg;
        den_next          = den_reg;
        rel_next          = rel_reg;
        res_speed_next    = res_speed_reg;
        res_status_next   = res_status_reg;
        res_idle_next     = res_idle_reg;
        res_last_next     = res_last_reg;
        out_speed_next    = out_speed_reg;
        out_status_next   = out_status_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next   = s_axis_tuser[0];
                    cap_next   = TIMER_BITS'(s_axis_tdata);
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                res_last_next = last_capture_reg;
                if (cmd_reg == CMD_TICK)
                begin
                    if (idle_inc >= cfg.timeout_ticks)
                    begin
                        res_speed_next  = '0;
                        res_idle_next   = '0;
                        res_status_next = ST_TIMEOUT;
                    end
                    else
                    begin
                        res_speed_next  = held_speed_reg;
                        res_idle_next   = idle_inc;
                        res_status_next = ST_TICK;
                    end
                    state_next = S_WB;
                end
                else if (glitch)
                begin
                    res_speed_next  = held_speed_reg;
                    res_idle_next   = idle_count_reg;
                    res_status_next = ST_GLITCH;
                    state_next      = S_WB;
                end
                else
                begin
                    period_next = period;
                    state_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                den_next   = DW'(period_reg) * DW'(cfg.pulses_per_rev);
                state_next = S_DSTART;
            end
            S_DSTART:
            begin
                state_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (div_done)
                begin
                    rel_next   = div_quo;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                res_last_next = cap_reg;
                res_idle_next = '0;
                if ((speed_diff != '0) && (speed_diff < cfg.max_step))
                begin
                    res_speed_next  = rel_reg;
                    res_status_next = ST_UPDATED;
                end
                else
                begin
                    res_speed_next  = held_speed_reg;
                    res_status_next = ST_KEPT;
                end
                state_next = S_WB;
            end
            S_WB:
            begin
                if (out_load)
                begin
                    out_valid_next    = 1'b1;
                    out_speed_next    = res_speed_reg;
                    out_status_next   = res_status_reg;
                    held_speed_next   = res_speed_reg;
                    idle_count_next   = res_idle_reg;
                    last_capture_next = res_last_reg;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            last_capture_reg <= '0;
            held_speed_reg   <= '0;
            idle_count_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            last_capture_reg <= last_capture_next;
            held_speed_reg   <= held_speed_next;
            idle_count_reg   <= idle_count_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        cap_reg        <= cap_next;
        period_reg     <= period_next;
        den_reg        <= den_next;
        rel_reg        <= rel_next;
        res_speed_reg  <= res_speed_next;
        res_status_reg <= res_status_next;
        res_idle_reg   <= res_idle_next;
        res_last_reg   <= res_last_next;
        out_speed_reg  <= out_speed_next;
        out_status_reg <= out_status_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_speed_reg;
    assign m_axis_tuser  = out_status_reg;

`ifndef SYNTH
    a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_EVAL))
        else $error("accepted beat not evaluated");
    a_div_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DWAIT && div_done) |=> (state_reg == S_STEP))
        else $error("divider result not taken");
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= ST_TIMEOUT))
        else $error("status code out of range");
    a_timeout_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_TIMEOUT) |-> (m_axis_tdata == '0))
        else $error("timeout result with nonzero speed");
    a_commit_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (held_speed_reg == m_axis_tdata) && m_axis_tvalid)
        else $error("held speed differs from delivered speed");
`endif

endmodule
